FILE: rtl/assert_macros.svh
// Shared assertion macros for the pending request table checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define RRPT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that an expression is never true outside reset.
`define RRPT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/rrpt_pkg.sv
`timescale 1ns / 1ps

package rrpt_pkg;

  localparam int ID_W = 32;

  typedef enum logic [2:0] {
    KIND_INSERT    = 3'd0,
    KIND_FIND_DEST = 3'd1,
    KIND_FIND_ID   = 3'd2,
    KIND_REM_DEST  = 3'd3,
    KIND_REM_ID    = 3'd4,
    KIND_EXP_QUERY = 3'd5,
    KIND_PURGE     = 3'd6,
    KIND_EARLIEST  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

FILE: rtl/rrpt_if.sv
`timescale 1ns / 1ps

// Request channel: one operation per beat.
interface rrpt_req_if #(
  parameter int ADDR_BITS = 16,
  parameter int TIME_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [ADDR_BITS-1:0]       dest;
  logic [rrpt_pkg::ID_W-1:0]  req_id;
  logic [TIME_BITS-1:0]       lifetime;
  logic [TIME_BITS-1:0]       now;

  modport source (output valid, kind, dest, req_id, lifetime, now, input ready);
  modport sink   (input valid, kind, dest, req_id, lifetime, now, output ready);
endinterface

// Response channel: one result per request beat.
interface rrpt_rsp_if #(
  parameter int ADDR_BITS = 16,
  parameter int TIME_BITS = 32,
  parameter int CNT_BITS  = 5
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic                       hit;
  logic                       expired;
  logic [ADDR_BITS-1:0]       out_dest;
  logic [rrpt_pkg::ID_W-1:0]  out_id;
  logic [TIME_BITS-1:0]       out_lifetime;
  logic [CNT_BITS-1:0]        removed;
  logic [CNT_BITS-1:0]        occupancy;

  modport source (output valid, status, hit, expired, out_dest, out_id, out_lifetime,
                  removed, occupancy, input ready);
  modport sink   (input valid, status, hit, expired, out_dest, out_id, out_lifetime,
                  removed, occupancy, output ready);
endinterface

FILE: rtl/rrpt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one registered read port.
module rrpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/route_request_pending_table.sv
`timescale 1ns / 1ps
// The result beat follows a scan over the N entries held (none on an empty table);
// the table RAM read port scans one entry a cycle.
// The next request is taken once the result is loaded, while that result may still wait.
// Reset clears the entry count and all control state; table contents stay undefined,
// no clearing pass is needed since only entries below the count are ever read.

module route_request_pending_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  rrpt_req_if.sink   req,
  rrpt_rsp_if.source rsp
);

  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W     = rrpt_pkg::ID_W;
  localparam int ENT_W    = ADDR_BITS + ID_W + TIME_BITS;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_DEPTH);

  // Sequencer: idle, scan of the table, result and table update.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  // Table bookkeeping.
  logic [CNT_BITS-1:0] count;   // entries held
  logic [CNT_BITS-1:0] rd_ptr;  // next entry to read
  logic [CNT_BITS-1:0] wr_ptr;  // compaction write slot
  logic [CNT_BITS-1:0] gone;    // entries dropped by this operation
  logic                ev_valid; // RAM read data holds an entry to evaluate

  // Operation held for the whole scan.
  rrpt_pkg::kind_t      op_kind;
  logic [ADDR_BITS-1:0] op_dest;
  logic [ID_W-1:0]      op_id;
  logic [TIME_BITS-1:0] op_life;
  logic [TIME_BITS-1:0] op_now;

  // Selected entry: first match, or earliest expiry so far.
  logic                 found;
  logic [ADDR_BITS-1:0] best_dest;
  logic [ID_W-1:0]      best_id;
  logic [TIME_BITS-1:0] best_exp;

  // Result register.
  logic                 rsp_valid;
  rrpt_pkg::status_t    rsp_status;
  logic                 rsp_hit;
  logic                 rsp_expired;
  logic [ADDR_BITS-1:0] rsp_dest;
  logic [ID_W-1:0]      rsp_id;
  logic [TIME_BITS-1:0] rsp_life;
  logic [CNT_BITS-1:0]  rsp_removed;
  logic [CNT_BITS-1:0]  rsp_occ;

  // RAM ports.
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  // Entry under evaluation.
  logic [ADDR_BITS-1:0] e_dest;
  logic [ID_W-1:0]      e_id;
  logic [TIME_BITS-1:0] e_exp;

  // Shared magnitude comparator and equality compares.
  logic [TIME_BITS-1:0] cmp_a;
  logic [TIME_BITS-1:0] cmp_b;
  logic                 cmp_le;
  logic                 dest_eq;
  logic                 id_eq;

  logic is_removal;
  logic key_match;
  logic take;
  logic rd_issue;
  logic done_go;
  logic ins_write;
  logic compact_write;

  // Result of the finishing cycle.
  rrpt_pkg::status_t    res_status;
  logic                 res_hit;
  logic                 res_expired;
  logic [CNT_BITS-1:0]  res_removed;
  logic [CNT_BITS-1:0]  count_next;

  assign e_dest = ram_rdata[ENT_W-1 -: ADDR_BITS];
  assign e_id   = ram_rdata[TIME_BITS +: ID_W];
  assign e_exp  = ram_rdata[TIME_BITS-1:0];

  assign dest_eq = (e_dest == op_dest);
  assign id_eq   = (e_id == op_id);

  // Steer the one comparator: expiry against now during a purge scan and for the
  // expiry verdict at the end, best-so-far against the entry when hunting the earliest.
  always_comb begin
    cmp_a = e_exp;
    cmp_b = op_now;
    if (state == S_DONE) begin
      cmp_a = best_exp;
    end else if (op_kind == rrpt_pkg::KIND_EARLIEST) begin
      cmp_a = best_exp;
      cmp_b = e_exp;
    end
  end

  assign cmp_le = (cmp_a <= cmp_b);

  always_comb begin
    unique case (op_kind) inside
      rrpt_pkg::KIND_REM_DEST, rrpt_pkg::KIND_REM_ID, rrpt_pkg::KIND_PURGE: is_removal = 1'b1;
      default: is_removal = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op_kind) inside
      rrpt_pkg::KIND_REM_DEST: key_match = dest_eq;
      rrpt_pkg::KIND_REM_ID:   key_match = id_eq;
      default:                 key_match = cmp_le;
    endcase
  end

  // Latch an entry: first match for lookups, strictly earlier expiry for the
  // earliest search so the entry inserted first wins a tie.
  always_comb begin
    unique case (op_kind) inside
      rrpt_pkg::KIND_INSERT, rrpt_pkg::KIND_FIND_DEST, rrpt_pkg::KIND_EXP_QUERY:
        take = dest_eq && !found;
      rrpt_pkg::KIND_FIND_ID:  take = id_eq && !found;
      rrpt_pkg::KIND_EARLIEST: take = !found || !cmp_le;
      default:                 take = 1'b0;
    endcase
  end

  assign rd_issue = (state == S_SCAN) && (rd_ptr != count);
  assign done_go  = !rsp_valid || rsp.ready;

  // Keep surviving entries in order; the write slot never passes the read slot.
  assign compact_write = (state == S_SCAN) && ev_valid && is_removal && !key_match;
  assign ins_write     = (state == S_DONE) && done_go && (op_kind == rrpt_pkg::KIND_INSERT)
                         && !found && (count != FULL_COUNT);

  assign ram_we    = compact_write || ins_write;
  assign ram_waddr = ins_write ? count[IDX_BITS-1:0] : wr_ptr[IDX_BITS-1:0];
  assign ram_wdata = ins_write ? {op_dest, op_id, op_life} : ram_rdata;

  rrpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Result of the operation, formed in the finishing cycle.
  always_comb begin
    res_status  = rrpt_pkg::ST_DONE;
    res_hit     = 1'b0;
    res_expired = 1'b0;
    res_removed = '0;
    count_next  = count;
    unique case (op_kind) inside
      rrpt_pkg::KIND_INSERT: begin
        if (found) begin
          res_status = rrpt_pkg::ST_DUPLICATE;
        end else if (count == FULL_COUNT) begin
          res_status = rrpt_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      rrpt_pkg::KIND_REM_DEST, rrpt_pkg::KIND_REM_ID: begin
        res_removed = gone;
        count_next  = wr_ptr;
        res_status  = (gone != '0) ? rrpt_pkg::ST_DONE : rrpt_pkg::ST_NOT_FOUND;
      end
      rrpt_pkg::KIND_PURGE: begin
        res_removed = gone;
        count_next  = wr_ptr;
      end
      default: begin
        res_hit     = found;
        res_status  = found ? rrpt_pkg::ST_DONE : rrpt_pkg::ST_NOT_FOUND;
        res_expired = found && cmp_le && (op_kind == rrpt_pkg::KIND_EXP_QUERY);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      gone      <= '0;
      ev_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state    <= S_SCAN;
            rd_ptr   <= '0;
            wr_ptr   <= '0;
            gone     <= '0;
            ev_valid <= 1'b0;
            found    <= 1'b0;
          end
        end
        S_SCAN: begin
          // Advance the read pointer; the RAM registers the read data.
          ev_valid <= rd_issue;
          if (rd_issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (ev_valid) begin
            if (take) begin
              found <= 1'b1;
            end
            if (is_removal) begin
              if (key_match) begin
                gone <= gone + 1'b1;
              end else begin
                wr_ptr <= wr_ptr + 1'b1;
              end
            end
          end
          if (!rd_issue && !ev_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the result register is free.
          if (done_go) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Raise the result in the finishing cycle; drop it once the sink takes the beat.
      if (state == S_DONE && done_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_kind <= rrpt_pkg::kind_t'(req.kind);
      op_dest <= req.dest;
      op_id   <= req.req_id;
      op_life <= req.lifetime;
      op_now  <= req.now;
    end
    if (state == S_SCAN && ev_valid && take) begin
      best_dest <= e_dest;
      best_id   <= e_id;
      best_exp  <= e_exp;
    end
    if (state == S_DONE && done_go) begin
      rsp_status  <= res_status;
      rsp_hit     <= res_hit;
      rsp_expired <= res_expired;
      rsp_dest    <= res_hit ? best_dest : '0;
      rsp_id      <= res_hit ? best_id : '0;
      rsp_life    <= res_hit ? best_exp : '0;
      rsp_removed <= res_removed;
      rsp_occ     <= count_next;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.hit          = rsp_hit;
  assign rsp.expired      = rsp_expired;
  assign rsp.out_dest     = rsp_dest;
  assign rsp.out_id       = rsp_id;
  assign rsp.out_lifetime = rsp_life;
  assign rsp.removed      = rsp_removed;
  assign rsp.occupancy    = rsp_occ;

endmodule

FILE: rtl/rrpt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrpt_checker #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16,
  parameter int TIME_BITS   = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [1:0]                          status,
  input logic                                hit,
  input logic [ADDR_BITS-1:0]                out_dest,
  input logic [rrpt_pkg::ID_W-1:0]           out_id,
  input logic [TIME_BITS-1:0]                out_lifetime,
  input logic [$clog2(TABLE_DEPTH+1)-1:0]    occupancy
);

  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

  `RRPT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped while stalled")
  `RRPT_ASSERT(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while a scan runs")
  `RRPT_NEVER(a_occ_bound, clk, rst, rsp_valid && (occupancy > CNT_BITS'(TABLE_DEPTH)), "occupancy above table depth")
  `RRPT_ASSERT(a_miss_zero, clk, rst, rsp_valid && !hit |-> out_dest == '0 && out_id == '0 && out_lifetime == '0, "entry fields set without a hit")
  `RRPT_ASSERT(a_hit_done, clk, rst, rsp_valid && hit |-> status == rrpt_pkg::ST_DONE, "hit with a failing status")

endmodule

bind route_request_pending_table rrpt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .ADDR_BITS   (ADDR_BITS),
  .TIME_BITS   (TIME_BITS)
) u_rrpt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .hit          (rsp.hit),
  .out_dest     (rsp.out_dest),
  .out_id       (rsp.out_id),
  .out_lifetime (rsp.out_lifetime),
  .occupancy    (rsp.occupancy)
);
